>>> design/swmd_pkg.sv
package swmd_pkg;

   localparam int DEPTH   = 64;
   localparam int ADDR_W  = $clog2(DEPTH);
   localparam int CNT_W   = $clog2(DEPTH + 1);
   localparam int WORD_W  = 32;
   localparam int OUT_CNT_W = 7;

   localparam logic [1:0] OP_PUSH   = 2'd0;
   localparam logic [1:0] OP_POP    = 2'd1;
   localparam logic [1:0] OP_DELMID = 2'd2;
   localparam logic [1:0] OP_READ   = 2'd3;

   localparam logic signed [WORD_W-1:0] EMPTY_WORD = -32'sd1;

   typedef struct packed {
      logic [1:0]               operation;
      logic signed [WORD_W-1:0] push_value;
   } req_type;

   typedef struct packed {
      logic signed [WORD_W-1:0] top_value;
      logic signed [WORD_W-1:0] middle_value;
      logic [OUT_CNT_W-1:0]     entry_count;
      logic                     is_empty;
      logic                     push_dropped;
   } rsp_type;

   typedef struct packed {
      logic capture;
      logic exec;
      logic shift;
      logic rd_top;
      logic rd_mid;
      logic load;
   } cmd_type;

   typedef struct packed {
      logic start_shift;
      logic shift_last;
      logic empty;
   } status_type;

endpackage

>>> design/stack_with_middle_delete_unit.sv
// Each request word is captured and executed; the top and middle entries are then read,
// and the result word is loaded and held. An empty stack skips the reads. A middle delete
// on two or more entries first moves the words above the middle down through the entry
// memory, which has one read and one write port and so moves one word a cycle.
// The next request word is taken the cycle after the result word is taken.
// Reset is synchronous and active high; it empties the stack and idles the controller,
// and it leaves the entry memory untouched.
module stack_with_middle_delete_unit (
   input  logic              clock,
   input  logic              reset,
   input  logic              req_valid,
   output logic              req_stall,
   input  swmd_pkg::req_type req_data,
   output logic              rsp_valid,
   input  logic              rsp_stall,
   output swmd_pkg::rsp_type rsp_data
);

   swmd_pkg::cmd_type    cmd;
   swmd_pkg::status_type status;

   swmd_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .status    (status),
      .cmd       (cmd)
   );

   swmd_datapath u_datapath (
      .clock    (clock),
      .reset    (reset),
      .req_data (req_data),
      .rsp_data (rsp_data),
      .cmd      (cmd),
      .status   (status)
   );

endmodule

>>> design/swmd_ctrl.sv
module swmd_ctrl (
   input  logic                clock,
   input  logic                reset,
   input  logic                req_valid,
   output logic                req_stall,
   output logic                rsp_valid,
   input  logic                rsp_stall,
   input  swmd_pkg::status_type status,
   output swmd_pkg::cmd_type    cmd
);

   localparam logic [2:0] ST_IDLE   = 3'd0;
   localparam logic [2:0] ST_EXEC   = 3'd1;
   localparam logic [2:0] ST_SHIFT  = 3'd2;
   localparam logic [2:0] ST_RD_TOP = 3'd3;
   localparam logic [2:0] ST_RD_MID = 3'd4;
   localparam logic [2:0] ST_LOAD   = 3'd5;
   localparam logic [2:0] ST_HOLD   = 3'd6;

   logic [2:0] state_ff;
   logic [2:0] state_in;

   assign req_stall = (state_ff != ST_IDLE);
   assign rsp_valid = (state_ff == ST_HOLD);

   always_comb begin
      state_in    = state_ff;
      cmd         = '0;
      unique case (state_ff)
         ST_IDLE: begin
            if (req_valid) begin
               cmd.capture = 1'b1;
               state_in    = ST_EXEC;
            end
         end
         ST_EXEC: begin
            cmd.exec = 1'b1;
            state_in = status.start_shift ? ST_SHIFT : ST_RD_TOP;
         end
         ST_SHIFT: begin
            cmd.shift = 1'b1;
            if (status.shift_last) begin
               state_in = ST_RD_TOP;
            end
         end
         ST_RD_TOP: begin
            // An empty stack needs no reads; the result carries the empty marker.
            if (status.empty) begin
               state_in = ST_LOAD;
            end else begin
               cmd.rd_top = 1'b1;
               state_in   = ST_RD_MID;
            end
         end
         ST_RD_MID: begin
            cmd.rd_mid = 1'b1;
            state_in   = ST_LOAD;
         end
         ST_LOAD: begin
            cmd.load = 1'b1;
            state_in = ST_HOLD;
         end
         ST_HOLD: begin
            if (!rsp_stall) begin
               state_in = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

endmodule

>>> design/swmd_datapath.sv
module swmd_datapath (
   input  logic                 clock,
   input  logic                 reset,
   input  swmd_pkg::req_type    req_data,
   output swmd_pkg::rsp_type    rsp_data,
   input  swmd_pkg::cmd_type    cmd,
   output swmd_pkg::status_type status
);

   logic [swmd_pkg::WORD_W-1:0] mem [swmd_pkg::DEPTH];

   logic [1:0]                        op_ff;
   logic signed [swmd_pkg::WORD_W-1:0] value_ff;
   logic [swmd_pkg::CNT_W-1:0]        count_ff;
   logic [swmd_pkg::CNT_W-1:0]        count_in;
   logic [swmd_pkg::ADDR_W-1:0]       shift_idx_ff;
   logic [swmd_pkg::ADDR_W-1:0]       shift_idx_in;
   logic                              dropped_ff;
   logic                              dropped_in;
   logic signed [swmd_pkg::WORD_W-1:0] top_ff;
   logic [swmd_pkg::WORD_W-1:0]       rd_data_ff;
   swmd_pkg::rsp_type                 rsp_ff;
   swmd_pkg::rsp_type                 rsp_in;

   logic                        wr_en;
   logic [swmd_pkg::ADDR_W-1:0] wr_addr;
   logic [swmd_pkg::WORD_W-1:0] wr_data;
   logic                        rd_en;
   logic [swmd_pkg::ADDR_W-1:0] rd_addr;
   logic [swmd_pkg::ADDR_W-1:0] mid_idx;
   logic                        shift_more;

   assign mid_idx    = swmd_pkg::ADDR_W'(count_ff >> 1);
   assign shift_more = (swmd_pkg::CNT_W'(shift_idx_ff) + swmd_pkg::CNT_W'(2)) < count_ff;

   assign status.start_shift = (op_ff == swmd_pkg::OP_DELMID) && (count_ff > swmd_pkg::CNT_W'(1));
   assign status.shift_last  = !shift_more;
   assign status.empty       = (count_ff == '0);

   assign rsp_data = rsp_ff;

   always_comb begin
      wr_en        = 1'b0;
      wr_addr      = '0;
      wr_data      = '0;
      rd_en        = 1'b0;
      rd_addr      = '0;
      count_in     = count_ff;
      shift_idx_in = shift_idx_ff;
      dropped_in   = dropped_ff;
      rsp_in       = rsp_ff;

      if (cmd.exec) begin
         dropped_in = 1'b0;
         case (op_ff)
            swmd_pkg::OP_PUSH: begin
               if (count_ff < swmd_pkg::CNT_W'(swmd_pkg::DEPTH)) begin
                  wr_en    = 1'b1;
                  wr_addr  = swmd_pkg::ADDR_W'(count_ff);
                  wr_data  = value_ff;
                  count_in = count_ff + swmd_pkg::CNT_W'(1);
               end else begin
                  dropped_in = 1'b1;
               end
            end
            swmd_pkg::OP_POP: begin
               if (count_ff != '0) begin
                  count_in = count_ff - swmd_pkg::CNT_W'(1);
               end
            end
            swmd_pkg::OP_DELMID: begin
               // With two or more entries the words above the middle move down
               // one place; a single entry is simply removed.
               if (count_ff > swmd_pkg::CNT_W'(1)) begin
                  rd_en        = 1'b1;
                  rd_addr      = mid_idx + swmd_pkg::ADDR_W'(1);
                  shift_idx_in = mid_idx;
               end else if (count_ff != '0) begin
                  count_in = '0;
               end
            end
            default: begin
            end
         endcase
      end

      if (cmd.shift) begin
         // The word read last cycle lands one place lower; the next read is
         // already under way.
         wr_en   = 1'b1;
         wr_addr = shift_idx_ff;
         wr_data = rd_data_ff;
         if (shift_more) begin
            rd_en        = 1'b1;
            rd_addr      = shift_idx_ff + swmd_pkg::ADDR_W'(2);
            shift_idx_in = shift_idx_ff + swmd_pkg::ADDR_W'(1);
         end else begin
            count_in = count_ff - swmd_pkg::CNT_W'(1);
         end
      end

      if (cmd.rd_top) begin
         rd_en   = 1'b1;
         rd_addr = swmd_pkg::ADDR_W'(count_ff - swmd_pkg::CNT_W'(1));
      end

      if (cmd.rd_mid) begin
         rd_en   = 1'b1;
         rd_addr = mid_idx;
      end

      if (cmd.load) begin
         rsp_in.entry_count  = swmd_pkg::OUT_CNT_W'(count_ff);
         rsp_in.is_empty     = (count_ff == '0);
         rsp_in.push_dropped = dropped_ff;
         if (count_ff == '0) begin
            rsp_in.top_value    = swmd_pkg::EMPTY_WORD;
            rsp_in.middle_value = swmd_pkg::EMPTY_WORD;
         end else begin
            rsp_in.top_value    = top_ff;
            rsp_in.middle_value = rd_data_ff;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem[rd_addr];
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.capture) begin
         op_ff    <= req_data.operation;
         value_ff <= req_data.push_value;
      end
      if (cmd.rd_mid) begin
         top_ff <= rd_data_ff;
      end
      shift_idx_ff <= shift_idx_in;
      dropped_ff   <= dropped_in;
      rsp_ff       <= rsp_in;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff <= '0;
      end else begin
         count_ff <= count_in;
      end
   end

endmodule

>>> design/swmd_checker.sv
module swmd_checker (
   input logic              clock,
   input logic              reset,
   input logic              req_valid,
   input logic              req_stall,
   input swmd_pkg::req_type req_data,
   input logic              rsp_valid,
   input logic              rsp_stall,
   input swmd_pkg::rsp_type rsp_data
);

   // A held result word keeps its contents.
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_stall |=> rsp_valid && $stable(rsp_data))
      else $error("result word changed while stalled");

   // The block works on one word at a time.
   assert property (@(posedge clock) disable iff (reset)
      req_valid && !req_stall |=> req_stall && !rsp_valid)
      else $error("request taken while another was in flight");

   assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> (rsp_data.is_empty == (rsp_data.entry_count == '0)) &&
                    (!rsp_data.is_empty ||
                     (rsp_data.top_value == swmd_pkg::EMPTY_WORD &&
                      rsp_data.middle_value == swmd_pkg::EMPTY_WORD)))
      else $error("empty flag does not match count or values");

   // A refused push only happens on a full stack.
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_data.push_dropped |->
         rsp_data.entry_count == swmd_pkg::OUT_CNT_W'(swmd_pkg::DEPTH))
      else $error("push dropped while stack not full");

endmodule

bind stack_with_middle_delete_unit swmd_checker u_swmd_checker (
   .clock     (clock),
   .reset     (reset),
   .req_valid (req_valid),
   .req_stall (req_stall),
   .req_data  (req_data),
   .rsp_valid (rsp_valid),
   .rsp_stall (rsp_stall),
   .rsp_data  (rsp_data)
);

>>> verif/stack_with_middle_delete_unit_tb.sv
module stack_with_middle_delete_unit_tb;

   localparam int RANDOM_WORDS = 2000;
   localparam int SETTLE_CYCLES = 40;
   localparam int CYCLE_LIMIT = 500000;

   // Mirrors the stack contents and predicts the result word of every request word.
   class stack_scoreboard;
      logic signed [swmd_pkg::WORD_W-1:0] words [swmd_pkg::DEPTH];
      int unsigned                        fill;
      swmd_pkg::rsp_type                  expected_q [$];
      int                                 errors;

      function new();
         fill = 0;
         errors = 0;
      endfunction

      function int pending();
         return expected_q.size();
      endfunction

      function int unsigned depth_used();
         return fill;
      endfunction

      function void note_request(swmd_pkg::req_type w);
         swmd_pkg::rsp_type r;
         int unsigned       mid_idx;
         r.push_dropped = 1'b0;
         case (w.operation)
            swmd_pkg::OP_PUSH: begin
               if (fill < swmd_pkg::DEPTH) begin
                  words[fill] = w.push_value;
                  fill++;
               end else begin
                  r.push_dropped = 1'b1;
               end
            end
            swmd_pkg::OP_POP: begin
               if (fill > 0) fill--;
            end
            swmd_pkg::OP_DELMID: begin
               // Close the gap by sliding everything above the middle down one slot.
               if (fill > 0) begin
                  mid_idx = fill / 2;
                  for (int unsigned i = mid_idx; i + 1 < fill; i++) words[i] = words[i + 1];
                  fill--;
               end
            end
            default: begin
            end
         endcase
         if (fill > 0) begin
            r.top_value = words[fill - 1];
            r.middle_value = words[fill / 2];
         end else begin
            r.top_value = swmd_pkg::EMPTY_WORD;
            r.middle_value = swmd_pkg::EMPTY_WORD;
         end
         r.entry_count = fill[swmd_pkg::OUT_CNT_W-1:0];
         r.is_empty = (fill == 0);
         expected_q.push_back(r);
      endfunction

      function void check_response(swmd_pkg::rsp_type got);
         swmd_pkg::rsp_type exp_w;
         if (expected_q.size() == 0) begin
            $error("result word arrived with none expected");
            errors++;
            return;
         end
         exp_w = expected_q.pop_front();
         if (got.top_value !== exp_w.top_value) begin
            $error("top_value: expected %0d, actual %0d", exp_w.top_value, got.top_value);
            errors++;
         end
         if (got.middle_value !== exp_w.middle_value) begin
            $error("middle_value: expected %0d, actual %0d", exp_w.middle_value,
                   got.middle_value);
            errors++;
         end
         if (got.entry_count !== exp_w.entry_count) begin
            $error("entry_count: expected %0d, actual %0d", exp_w.entry_count,
                   got.entry_count);
            errors++;
         end
         if (got.is_empty !== exp_w.is_empty) begin
            $error("is_empty: expected %0b, actual %0b", exp_w.is_empty, got.is_empty);
            errors++;
         end
         if (got.push_dropped !== exp_w.push_dropped) begin
            $error("push_dropped: expected %0b, actual %0b", exp_w.push_dropped,
                   got.push_dropped);
            errors++;
         end
      endfunction
   endclass

   logic              clock = 1'b0;
   logic              reset = 1'b1;
   logic              req_valid = 1'b0;
   logic              req_stall;
   swmd_pkg::req_type req_data = '0;
   logic              rsp_valid;
   logic              rsp_stall = 1'b0;
   swmd_pkg::rsp_type rsp_data;

   stack_scoreboard sb = new();
   int              words_sent = 0;
   int              cycle_count = 0;
   bit              req_quiet = 1'b0;
   bit              rsp_quiet = 1'b0;

   stack_with_middle_delete_unit dut (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .req_data  (req_data),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .rsp_data  (rsp_data)
   );

   always #6 clock = ~clock;

   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count >= CYCLE_LIMIT) begin
         $display("Regression FAIL");
         $finish;
      end
   end

   always @(posedge clock) begin
      if (!reset && req_valid && !req_stall) sb.note_request(req_data);
      if (!reset && rsp_valid && !rsp_stall) sb.check_response(rsp_data);
   end

   // Result side: after each taken word, stall for a random number of cycles.
   initial begin
      int stall_cycles;
      @(posedge clock);
      while (reset) @(posedge clock);
      forever begin
         if ($urandom_range(0, 49) == 0) rsp_quiet = ~rsp_quiet;
         stall_cycles = rsp_quiet ? 0 : $urandom_range(0, 4);
         if (stall_cycles > 0) begin
            rsp_stall <= 1'b1;
            repeat (stall_cycles) @(posedge clock);
         end
         rsp_stall <= 1'b0;
         @(posedge clock);
         while (!rsp_valid) @(posedge clock);
      end
   end

   // Returns at the edge where the word was taken; the next call drives in that step.
   task automatic send_word(input logic [1:0] op,
                            input logic signed [swmd_pkg::WORD_W-1:0] value);
      int gap;
      gap = req_quiet ? 0 : $urandom_range(0, 4);
      if (gap > 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_valid <= 1'b1;
      req_data <= '{operation: op, push_value: value};
      @(posedge clock);
      while (req_stall) @(posedge clock);
      words_sent++;
   endtask

   task automatic wait_for_results_drained();
      req_valid <= 1'b0;
      @(posedge clock);
      while (sb.pending() != 0) @(posedge clock);
   endtask

   function automatic logic signed [swmd_pkg::WORD_W-1:0] pick_value();
      case ($urandom_range(0, 7))
         0: return 32'sh8000_0000;
         1: return 32'sh7FFF_FFFF;
         2: return -32'sd1;
         3: return 32'sd0;
         default: return $urandom;
      endcase
   endfunction

   function automatic logic [1:0] pick_op(input int kind);
      int r;
      r = $urandom_range(0, 9);
      case (kind)
         0: return (r < 7) ? swmd_pkg::OP_PUSH :
                   ((r == 7) ? swmd_pkg::OP_POP :
                    ((r == 8) ? swmd_pkg::OP_DELMID : swmd_pkg::OP_READ));
         1: return (r < 4) ? swmd_pkg::OP_POP :
                   ((r < 8) ? swmd_pkg::OP_DELMID :
                    ((r == 8) ? swmd_pkg::OP_PUSH : swmd_pkg::OP_READ));
         default: return 2'($urandom_range(0, 3));
      endcase
   endfunction

   initial begin
      int kind;
      int span;
      repeat (4) @(posedge clock);
      reset <= 1'b0;

      // Empty-stack corner cases, single-entry middle delete, extreme values.
      send_word(swmd_pkg::OP_READ, $urandom);
      send_word(swmd_pkg::OP_POP, $urandom);
      send_word(swmd_pkg::OP_DELMID, $urandom);
      send_word(swmd_pkg::OP_PUSH, 32'sh7FFF_FFFF);
      send_word(swmd_pkg::OP_DELMID, $urandom);
      send_word(swmd_pkg::OP_PUSH, 32'sh8000_0000);
      send_word(swmd_pkg::OP_PUSH, -32'sd1);
      send_word(swmd_pkg::OP_PUSH, 32'sd0);
      send_word(swmd_pkg::OP_READ, 32'sh5A5A_A5A5);
      send_word(swmd_pkg::OP_DELMID, $urandom);
      send_word(swmd_pkg::OP_POP, $urandom);
      send_word(swmd_pkg::OP_POP, $urandom);
      send_word(swmd_pkg::OP_POP, $urandom);
      send_word(swmd_pkg::OP_PUSH, 32'sh5555_5555);
      send_word(swmd_pkg::OP_PUSH, 32'shAAAA_AAAA);
      send_word(swmd_pkg::OP_PUSH, 32'sd1);
      send_word(swmd_pkg::OP_PUSH, 32'sd2);
      send_word(swmd_pkg::OP_DELMID, $urandom);
      send_word(swmd_pkg::OP_DELMID, $urandom);
      send_word(swmd_pkg::OP_READ, $urandom);
      send_word(swmd_pkg::OP_DELMID, $urandom);
      send_word(swmd_pkg::OP_DELMID, $urandom);
      wait_for_results_drained();

      words_sent = 0;
      while (words_sent < RANDOM_WORDS) begin
         kind = $urandom_range(0, 4);
         span = $urandom_range(20, 100);
         req_quiet = ($urandom_range(0, 3) == 0);
         case (kind)
            3: begin
               // Fill to the limit, then push into a full stack.
               while (sb.depth_used() < swmd_pkg::DEPTH)
                  send_word(swmd_pkg::OP_PUSH, pick_value());
               repeat ($urandom_range(1, 4)) send_word(swmd_pkg::OP_PUSH, pick_value());
               send_word(swmd_pkg::OP_READ, $urandom);
               send_word(swmd_pkg::OP_DELMID, $urandom);
               send_word(swmd_pkg::OP_PUSH, pick_value());
            end
            4: begin
               // Empty the stack mostly through middle deletes.
               while (sb.depth_used() > 0)
                  send_word(($urandom_range(0, 5) == 0) ? swmd_pkg::OP_POP :
                            swmd_pkg::OP_DELMID, $urandom);
               send_word(swmd_pkg::OP_DELMID, $urandom);
               send_word(swmd_pkg::OP_POP, $urandom);
            end
            default: begin
               repeat (span) send_word(pick_op(kind), pick_value());
            end
         endcase
         if ($urandom_range(0, 7) == 0) wait_for_results_drained();
      end

      req_valid <= 1'b0;
      @(posedge clock);
      while (sb.pending() != 0) @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
      if (sb.pending() != 0) begin
         $error("%0d expected result words never arrived", sb.pending());
         sb.errors++;
      end
      if (sb.errors == 0) begin
         $display("Regression PASS");
      end else begin
         $display("Regression FAIL");
      end
      $finish;
   end

endmodule
